// File: sv/sap_pkg.sv
// Shared types and constants for the scored anchor pool.
package sap_pkg;
    localparam int PoolEntries = 6;
    localparam int SelectCount = 4;
    localparam int ScoreW = 48;

    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_START  = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_ALPHA  = 2'd0,
        CFG_DECAY  = 2'd1,
        CFG_WEIGHT = 2'd2,
        CFG_SPARE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         anchor_id;
        logic signed [31:0] chan_power;
        logic [15:0]        chan_quality;
    } t_in_item;

    typedef struct packed {
        logic [7:0] sel_id;
        logic [1:0] sel_rank;
        logic [2:0] selected_count;
        logic       sel_valid;
        logic       sel_last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  idx;
        logic [15:0] data;
    } t_cfg_item;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // latch input item, compute report score
        logic mul_a;     // blend product stage one
        logic mul_b;     // blend product stage two
        logic wr_rep;    // write report result
        logic clr_seen;  // start round
        logic dec_step;  // decay one entry at scan index
        logic sel_clr;   // clear taken bits
        logic sel_step;  // visit one entry in the selection scan
        logic sel_take;  // mark best taken, latch result
        logic scan_rst;  // reset scan index
    } t_cmd;

    typedef struct packed {
        logic       scan_end;
        logic [4:0] count;
    } t_sts;

    function automatic logic signed [ScoreW-1:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] mx;
        logic signed [63:0] mn;
        mx = 64'sh0000_7FFF_FFFF_FFFF;
        mn = -mx - 64'sd1;
        if (v > mx) return mx[ScoreW-1:0];
        if (v < mn) return mn[ScoreW-1:0];
        return v[ScoreW-1:0];
    endfunction

    // floor((v+128)/256)
    function automatic logic signed [63:0] rnd8(input logic signed [63:0] v);
        logic signed [63:0] x;
        x = v + 64'sd128;
        return x >>> 8;
    endfunction
endpackage

// File: sv/sap_datapath.sv
// Pool storage, score arithmetic and scan logic.
module sap_datapath #(
    parameter int P_ENTRIES = sap_pkg::PoolEntries
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sap_pkg::t_in_item  i_item,
    input  sap_pkg::t_cfg_item i_cfg,
    input  logic               i_cfg_we,
    input  sap_pkg::t_cmd      i_cmd,
    output sap_pkg::t_sts      o_sts,
    output logic [7:0]         o_best_id
);
    import sap_pkg::*;
    localparam int IW = $clog2(P_ENTRIES);
    localparam int CW = $clog2(P_ENTRIES + 1);

    logic [8:0]  r_alpha, r_decay;
    logic [15:0] r_weight;
    logic [7:0]               r_id [P_ENTRIES];
    logic signed [ScoreW-1:0] r_score [P_ENTRIES];
    logic [P_ENTRIES-1:0] r_valid, r_seen, r_taken;
    logic [7:0]               r_in_id;
    logic signed [ScoreW-1:0] r_new;
    logic [IW-1:0]            r_tgt;
    logic                     r_hit;
    logic signed [63:0]       r_pa, r_pb;
    logic [IW:0]              r_scan;
    logic [IW-1:0]            r_best;
    logic                     r_have;

    logic [8:0] alpha_c, decay_c;
    assign alpha_c = (r_alpha > 9'd256) ? 9'd256 : r_alpha;
    assign decay_c = (r_decay > 9'd256) ? 9'd256 : r_decay;

    // Quality term: 16 by 16 bits.
    logic [31:0] wq;
    assign wq = r_weight * i_item.chan_quality;

    // Score of the report and target slot search (id, free and score compares over all entries).
    logic signed [63:0] rep_raw;
    logic [IW-1:0] hit_i, free_i, worst_i;
    logic hit_f, free_f;
    always_comb begin
        rep_raw = 64'(signed'(i_item.chan_power)) * 64'sd256 + 64'(wq);
        hit_f = 1'b0; free_f = 1'b0;
        hit_i = '0; free_i = '0; worst_i = '0;
        for (int i = 0; i < P_ENTRIES; i++) begin
            if (!hit_f && r_valid[i] && r_id[i] == i_item.anchor_id) begin
                hit_f = 1'b1; hit_i = IW'(i);
            end
            if (!free_f && !r_valid[i]) begin
                free_f = 1'b1; free_i = IW'(i);
            end
            if (r_score[i] < r_score[worst_i]) worst_i = IW'(i);
        end
    end

    logic [IW-1:0] sidx;
    logic [CW-1:0] cnt;
    assign sidx = r_scan[IW-1:0];
    always_comb begin
        cnt = '0;
        for (int i = 0; i < P_ENTRIES; i++) cnt = cnt + CW'(r_valid[i]);
    end
    assign o_sts.scan_end = (r_scan == (IW+1)'(P_ENTRIES - 1));
    assign o_sts.count = 5'(cnt);
    assign o_best_id = r_id[r_best];

    logic signed [63:0] old_s;
    assign old_s = 64'(r_score[r_tgt]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 9'd77; r_decay <= 9'd128; r_weight <= 16'd256;
            r_valid <= '0; r_seen <= '0; r_taken <= '0;
            r_scan <= '0; r_have <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg.idx))
                    CFG_ALPHA:  r_alpha <= i_cfg.data[8:0];
                    CFG_DECAY:  r_decay <= i_cfg.data[8:0];
                    CFG_WEIGHT: r_weight <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_in_id <= i_item.anchor_id;
                r_new <= sat48(rep_raw);
                r_hit <= hit_f;
                r_tgt <= hit_f ? hit_i : (free_f ? free_i : worst_i);
            end
            if (i_cmd.mul_a) r_pa <= 64'(signed'({1'b0, alpha_c})) * 64'(r_new);
            if (i_cmd.mul_b) r_pb <= 64'(signed'({1'b0, 9'd256 - alpha_c})) * old_s;
            if (i_cmd.wr_rep) begin
                r_score[r_tgt] <= r_hit ? sat48(rnd8(r_pa + r_pb)) : r_new;
                if (!r_hit) r_id[r_tgt] <= r_in_id;
                r_valid[r_tgt] <= 1'b1;
                r_seen[r_tgt] <= 1'b1;
            end
            if (i_cmd.clr_seen) r_seen <= '0;
            if (i_cmd.scan_rst) begin
                r_scan <= '0; r_have <= 1'b0;
            end else if (i_cmd.dec_step || i_cmd.sel_step) begin
                r_scan <= r_scan + (IW+1)'(1);
            end
            if (i_cmd.dec_step && r_valid[sidx] && !r_seen[sidx])
                r_score[sidx] <= sat48(rnd8(64'(r_score[sidx])
                                 * 64'(signed'({1'b0, decay_c}))));
            if (i_cmd.sel_clr) r_taken <= '0;
            if (i_cmd.sel_step && r_valid[sidx] && !r_taken[sidx]
                && (!r_have || r_score[sidx] > r_score[r_best])) begin
                r_best <= sidx; r_have <= 1'b1;
            end
            if (i_cmd.sel_take) r_taken[r_best] <= 1'b1;
        end
    end
endmodule

// File: sv/sap_ctrl.sv
// Sequencer for report, start, finish and selection.
module sap_ctrl #(
    parameter int P_SELECT = sap_pkg::SelectCount
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_op,
    input  sap_pkg::t_sts       i_sts,
    input  logic [7:0]          i_best_id,
    output sap_pkg::t_cmd       o_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output sap_pkg::t_out_item  o_item
);
    import sap_pkg::*;
    typedef enum logic [2:0] {
        S_IDLE, S_MA, S_MB, S_WR, S_DEC, S_SCAN, S_PICK, S_OUT
    } t_state;
    t_state r_st;
    logic [2:0] r_rank;
    logic [4:0] r_n;

    assign o_ready = (r_st == S_IDLE);
    wire acc = i_valid && o_ready;

    always_comb begin
        o_cmd = '0;
        o_cmd.load = acc && t_op'(i_op) == OP_REPORT;
        o_cmd.clr_seen = acc && t_op'(i_op) == OP_START;
        o_cmd.scan_rst = (acc && t_op'(i_op) == OP_FINISH) || (r_st == S_DEC && i_sts.scan_end)
                      || (r_st == S_OUT && o_valid && i_ready);
        o_cmd.sel_clr = acc && t_op'(i_op) == OP_FINISH;
        o_cmd.mul_a = (r_st == S_MA);
        o_cmd.mul_b = (r_st == S_MB);
        o_cmd.wr_rep = (r_st == S_WR);
        o_cmd.dec_step = (r_st == S_DEC);
        o_cmd.sel_step = (r_st == S_SCAN);
        // best index is settled in the cycle after the last scan step
        o_cmd.sel_take = (r_st == S_PICK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; o_valid <= 1'b0; r_rank <= '0; r_n <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (acc) begin
                    case (t_op'(i_op))
                        OP_REPORT: r_st <= S_MA;
                        OP_FINISH: r_st <= S_DEC;
                        default:   r_st <= S_IDLE;
                    endcase
                end
                S_MA: r_st <= S_MB;
                S_MB: r_st <= S_WR;
                S_WR: r_st <= S_IDLE;
                S_DEC: if (i_sts.scan_end) begin
                    r_rank <= '0;
                    r_n <= (i_sts.count > 5'(P_SELECT)) ? 5'(P_SELECT) : i_sts.count;
                    if (i_sts.count == 5'd0) begin
                        o_item <= '{sel_id: 8'd0, sel_rank: 2'd0, selected_count: 3'd0,
                                    sel_valid: 1'b0, sel_last: 1'b1};
                        o_valid <= 1'b1;
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_SCAN;
                    end
                end
                S_SCAN: if (i_sts.scan_end) r_st <= S_PICK;
                S_PICK: begin
                    r_st <= S_OUT;
                    o_valid <= 1'b1;
                    o_item <= '{sel_id: i_best_id, sel_rank: r_rank[1:0],
                                selected_count: r_n[2:0], sel_valid: 1'b1,
                                sel_last: (5'(r_rank) == r_n - 5'd1)};
                end
                S_OUT: if (i_ready) begin
                    o_valid <= 1'b0;
                    if (o_item.sel_last) r_st <= S_IDLE;
                    else begin
                        r_rank <= r_rank + 3'd1;
                        r_st <= S_SCAN;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/scored_anchor_pool_top_k_unit.sv
// Top level of the scored anchor pool with top-k selection.
// Report: search, two blend products, write back. Start: clears the seen flags.
// Finish: decay of every entry, then per result one scan over all entries,
// one pick step and one output handshake.
// Empty pool: decay, then a single empty last item.
// One item in flight; sync active-low reset clears valid, seen and taken and restores default config.
module scored_anchor_pool_top_k_unit #(
    parameter int P_ENTRIES = sap_pkg::PoolEntries,
    parameter int P_SELECT  = sap_pkg::SelectCount
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sap_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output sap_pkg::t_out_item o_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  sap_pkg::t_cfg_item i_cfg
);
    import sap_pkg::*;
    t_cmd cmd;
    t_sts sts;
    logic [7:0] best_id;
    assign o_cfg_ready = 1'b1;

    sap_datapath #(.P_ENTRIES(P_ENTRIES)) u_dp (
        .i_clk, .i_rst_n, .i_item, .i_cfg, .i_cfg_we(i_cfg_valid),
        .i_cmd(cmd), .o_sts(sts), .o_best_id(best_id));

    sap_ctrl #(.P_SELECT(P_SELECT)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op(i_item.op), .i_sts(sts),
        .i_best_id(best_id), .o_cmd(cmd), .o_valid, .i_ready, .o_item);

    a_one_way: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("input taken during output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.wr_rep && cmd.dec_step)) else $error("conflicting writes");
endmodule
